// ===== rtl/thermocouple_linearizer_cjc_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the thermocouple linearizer
// Concurrent checks on the rising edge of clk, disabled while rst_n is low.
// Synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef THERMOCOUPLE_LINEARIZER_CJC_MACROS_SVH
`define THERMOCOUPLE_LINEARIZER_CJC_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define TLC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlc same-cycle check failed");
// Next-cycle implication
`define TLC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlc next-cycle check failed");
`else
`define TLC_ASSERT_IMP(name, ante, cons)
`define TLC_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== rtl/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, K-type calibration points and pipeline latencies.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int ROM_POINTS = 8;
  localparam int SEG_W      = $clog2(ROM_POINTS);
  localparam int RECIP_W    = 20;
  localparam int RATIO_W    = 20;

  // Pipeline depths of the sub-blocks
  localparam int HANDLE_LAT = 3;
  localparam int PWL_LAT    = 6;

  // Configuration space: one 32-bit register word
  localparam int   CFG_ADDR_W  = 3;
  localparam logic CFG_IDX_CAL = 1'b0;

  typedef logic [15:0]        word_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [RECIP_W-1:0] recip_t;
  typedef logic [RATIO_W-1:0] ratio_t;

  // Raw amplifier samples at each calibration point
  localparam word_t ROM_RAW [ROM_POINTS] = '{
    16'd0, 16'd4664, 16'd9296, 16'd13961, 16'd18593, 16'd23226, 16'd27890, 16'd32538
  };
  // Celsius in fx9.7 at each calibration point
  localparam word_t ROM_CEL [ROM_POINTS] = '{
    16'd0, 16'd9294, 16'd18447, 16'd27902, 16'd37139, 16'd44881, 16'd55139, 16'd64000
  };
  // floor(2^32 / segment width) for the segment ending at each point, raw keys
  localparam recip_t RECIP_RAW [ROM_POINTS] = '{
    20'd0, 20'd920876, 20'd927238, 20'd920678, 20'd927238, 20'd927038, 20'd920876,
    20'd924046
  };
  // Same for Celsius keys
  localparam recip_t RECIP_CEL [ROM_POINTS] = '{
    20'd0, 20'd462122, 20'd469241, 20'd454253, 20'd464974, 20'd554761, 20'd418694,
    20'd484704
  };

  // Key column: raw for the forward direction, Celsius for the inverse
  function automatic word_t rom_key(input logic fwd, input seg_t idx);
    return fwd ? ROM_RAW[idx] : ROM_CEL[idx];
  endfunction

  function automatic word_t rom_val(input logic fwd, input seg_t idx);
    return fwd ? ROM_CEL[idx] : ROM_RAW[idx];
  endfunction

  function automatic recip_t rom_recip(input logic fwd, input seg_t idx);
    return fwd ? RECIP_RAW[idx] : RECIP_CEL[idx];
  endfunction

endpackage

// ===== rtl/tlc_handle.sv =====
// ----------------------------------------------------------------------------
// tlc_handle
// Three-stage conversion of the handle sensor reading to fx9.7 Celsius.
// ----------------------------------------------------------------------------
module tlc_handle (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [14:0]   in_handle_sample,
  output logic          out_valid,
  output tlc_pkg::word_t out_h97
);
  import tlc_pkg::*;

  localparam int               M_W          = 22;
  localparam int               Q_W          = 12;
  localparam int               RECIP_SHIFT  = 32;
  localparam int               FX_SHIFT     = 9;
  localparam logic signed [15:0] HANDLE_ZERO = 16'sd4965;
  localparam logic [6:0]       HANDLE_NUM   = 7'd100;
  // ceil(2^32 / 993): exact quotient for every product below 2^22
  localparam logic [22:0]      HANDLE_RECIP = 23'd4325245;
  localparam logic [12:0]      TENTH_FX     = 13'd6553;

  logic signed [15:0] diff;
  logic [14:0]        mag;
  logic [M_W-1:0]     m_nxt;
  logic [44:0]        q_prod;
  logic [15:0]        hx10;
  logic [28:0]        h_prod;

  logic           s1_valid_r, s2_valid_r, s3_valid_r;
  logic           s1_neg_r, s2_neg_r;
  logic [M_W-1:0] s1_m_r;
  logic [Q_W-1:0] s2_q_r;
  word_t          s3_h97_r;

  // Stage 1: remove the zero point and scale the magnitude by 100
  always_comb begin
    diff  = $signed({1'b0, in_handle_sample}) - HANDLE_ZERO;
    mag   = diff[15] ? 15'(-diff) : 15'(diff);
    m_nxt = {7'd0, mag} * {15'd0, HANDLE_NUM};
  end

  // Stage 2: divide by 993 through the reciprocal
  assign q_prod = {23'd0, s1_m_r} * {22'd0, HANDLE_RECIP};

  // Stage 3: restore the sign, wrap to 16 bits and convert tenths to fx9.7
  always_comb begin
    hx10   = s2_neg_r ? (16'd0 - {4'd0, s2_q_r}) : {4'd0, s2_q_r};
    h_prod = {13'd0, hx10} * {16'd0, TENTH_FX};
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    s1_neg_r <= diff[15];
    s1_m_r   <= m_nxt;
    s2_neg_r <= s1_neg_r;
    s2_q_r   <= q_prod[RECIP_SHIFT +: Q_W];
    s3_h97_r <= h_prod[FX_SHIFT +: 16];
  end

  assign out_valid = s3_valid_r;
  assign out_h97   = s3_h97_r;

endmodule

// ===== rtl/tlc_pwl.sv =====
// ----------------------------------------------------------------------------
// tlc_pwl
// Six-stage piecewise-linear interpolation in the K-type point table, with
// the segment ratio formed by reciprocal multiply and remainder correction.
// ----------------------------------------------------------------------------
module tlc_pwl #(
  parameter int TABLE_ENTRIES = 8,
  parameter bit FORWARD       = 1'b1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  tlc_pkg::word_t in_x,
  output logic           out_valid,
  output tlc_pkg::word_t out_y
);
  import tlc_pkg::*;

  localparam int   N_CLAMP  = (TABLE_ENTRIES < ROM_POINTS) ? TABLE_ENTRIES : ROM_POINTS;
  localparam int   N_USED   = (N_CLAMP < 2) ? 2 : N_CLAMP;
  localparam seg_t SEG_LAST = SEG_W'(N_USED - 1);

  seg_t   seg, seg_prev;
  word_t  key_lo, key_hi;
  logic [35:0] ar_prod;
  logic [35:0] qb_prod;
  logic [31:0] rem;
  ratio_t ratio_nxt;
  logic [35:0] dr_prod;

  logic   s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, s6_valid_r;
  word_t  s1_a_r, s1_b_r, s1_v0_r, s1_dv_r;
  recip_t s1_recip_r;
  word_t  s2_a_r, s2_b_r, s2_v0_r, s2_dv_r;
  ratio_t s2_q0_r;
  word_t  s3_a_r, s3_b_r, s3_v0_r, s3_dv_r;
  ratio_t s3_q0_r;
  logic [31:0] s3_qb_r;
  word_t  s4_v0_r, s4_dv_r;
  ratio_t s4_ratio_r;
  word_t  s5_v0_r, s5_pt_r;
  word_t  s6_y_r;

  // Stage 1: pick the first point above the key, else the last segment
  always_comb begin
    seg = SEG_LAST;
    for (int k = N_USED - 1; k >= 1; k--) begin
      if (rom_key(FORWARD, SEG_W'(k)) > in_x) begin
        seg = SEG_W'(k);
      end
    end
    seg_prev = seg - 1'b1;
    key_lo   = rom_key(FORWARD, seg_prev);
    key_hi   = rom_key(FORWARD, seg);
  end

  // Stage 2: estimate of (a << 16) / b, low by at most one
  assign ar_prod = {20'd0, s1_a_r} * {16'd0, s1_recip_r};

  // Stage 3: multiply the estimate back by the segment width
  assign qb_prod = {16'd0, s2_q0_r} * {20'd0, s2_b_r};

  // Stage 4: correct the estimate from the remainder
  always_comb begin
    rem       = {s3_a_r, 16'h0000} - s3_qb_r;
    ratio_nxt = s3_q0_r + RATIO_W'(rem >= {16'h0000, s3_b_r});
  end

  // Stage 5: scale the value step by the ratio
  assign dr_prod = {20'd0, s4_dv_r} * {16'd0, s4_ratio_r};

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    s1_a_r     <= in_x - key_lo;
    s1_b_r     <= key_hi - key_lo;
    s1_recip_r <= rom_recip(FORWARD, seg);
    s1_v0_r    <= rom_val(FORWARD, seg_prev);
    s1_dv_r    <= rom_val(FORWARD, seg) - rom_val(FORWARD, seg_prev);

    s2_a_r  <= s1_a_r;
    s2_b_r  <= s1_b_r;
    s2_v0_r <= s1_v0_r;
    s2_dv_r <= s1_dv_r;
    s2_q0_r <= ar_prod[16 +: RATIO_W];

    s3_a_r  <= s2_a_r;
    s3_b_r  <= s2_b_r;
    s3_v0_r <= s2_v0_r;
    s3_dv_r <= s2_dv_r;
    s3_q0_r <= s2_q0_r;
    s3_qb_r <= qb_prod[31:0];

    s4_v0_r    <= s3_v0_r;
    s4_dv_r    <= s3_dv_r;
    s4_ratio_r <= ratio_nxt;

    s5_v0_r <= s4_v0_r;
    s5_pt_r <= dr_prod[16 +: 16];

    // Stage 6: add the interpolated step to the segment base, wrapping
    s6_y_r <= s5_v0_r + s5_pt_r;
  end

  assign out_valid = s6_valid_r;
  assign out_y     = s6_y_r;

endmodule

// ===== rtl/tlc_units.sv =====
// ----------------------------------------------------------------------------
// tlc_units
// Output register: fx9.7, whole Celsius and whole Fahrenheit.
// ----------------------------------------------------------------------------
module tlc_units (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  tlc_pkg::word_t in_fx97,
  output logic           out_valid,
  output tlc_pkg::word_t out_fx97,
  output logic [8:0]     out_celsius,
  output logic [9:0]     out_fahrenheit
);
  import tlc_pkg::*;

  // ceil(2^16 / 5): exact quotient for every dividend up to 9 * 511
  localparam logic [13:0] DIV5_RECIP = 14'd13108;
  localparam logic [9:0]  F_OFFSET   = 10'd32;

  logic [8:0]  cel;
  logic [12:0] nine;
  logic [26:0] div_prod;

  logic        valid_r;
  word_t       fx97_r;
  logic [8:0]  cel_r;
  logic [9:0]  fahr_r;

  // Form Celsius times nine and divide by five
  always_comb begin
    cel      = in_fx97[15:7];
    nine     = {1'b0, cel, 3'b000} + {4'd0, cel};
    div_prod = {14'd0, nine} * {13'd0, DIV5_RECIP};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk) begin
    fx97_r <= in_fx97;
    cel_r  <= cel;
    fahr_r <= div_prod[16 +: 10] + F_OFFSET;
  end

  assign out_valid      = valid_r;
  assign out_fx97       = fx97_r;
  assign out_celsius    = cel_r;
  assign out_fahrenheit = fahr_r;

endmodule

// ===== rtl/thermocouple_linearizer_cjc.sv =====
// ----------------------------------------------------------------------------
// thermocouple_linearizer_cjc
// K-type thermocouple linearizer with cold-junction compensation.
// ----------------------------------------------------------------------------
// The block takes one request on every clock cycle: busy is held low, so a
// request is accepted at any edge where start is high. Each result appears on
// the out_ ports in request order, flagged by out_valid for exactly one
// cycle, and the receiver cannot hold it off. A request passes through the
// three-stage handle sensor conversion, two six-stage interpolation
// pipelines (the cold-junction lookup and the forward linearisation, each
// forming its segment ratio by reciprocal multiply and one correction step),
// the compensation adder and the output register. calibration_offset is
// written over the APB port at word 0 and should change only while no
// request is in flight.
module thermocouple_linearizer_cjc #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [15:0]                    in_tip_sample,
  input  logic [14:0]                    in_handle_sample,
  output logic                           out_valid,
  output logic [15:0]                    out_temp_fx97,
  output logic [8:0]                     out_temp_celsius,
  output logic [9:0]                     out_temp_fahrenheit,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tlc_pkg::*;

  localparam int TIP_DLY = HANDLE_LAT + PWL_LAT;
  localparam int LAT     = HANDLE_LAT + 2 * PWL_LAT + 2;

  logic  in_req;
  logic  cfg_wr;
  logic  cfg_hit;
  word_t calibration_offset_r;

  logic  h_valid;
  word_t h97;
  logic  cj_valid;
  word_t cj;
  logic  fx_valid;
  word_t fx97;

  word_t tip_dly_r [TIP_DLY];
  logic  sample_valid_r;
  word_t sample_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign in_req = start && !busy;

  // Configuration register
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == CFG_IDX_CAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calibration_offset_r <= '0;
    end else if (cfg_wr && cfg_hit) begin
      calibration_offset_r <= pwdata[15:0];
    end
  end

  assign prdata = cfg_hit ? {{16{calibration_offset_r[15]}}, calibration_offset_r} : 32'h0;

  // Handle sensor to fx9.7 Celsius
  tlc_handle u_handle (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_req),
    .in_handle_sample (in_handle_sample),
    .out_valid        (h_valid),
    .out_h97          (h97)
  );

  // Cold-junction temperature back to a raw sample offset
  tlc_pwl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FORWARD       (1'b0)
  ) u_pwl_cj (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h_valid),
    .in_x      (h97),
    .out_valid (cj_valid),
    .out_y     (cj)
  );

  // Delay the tip sample to meet the cold-junction offset
  always_ff @(posedge clk) begin
    tip_dly_r[0] <= in_tip_sample;
    for (int k = 1; k < TIP_DLY; k++) begin
      tip_dly_r[k] <= tip_dly_r[k-1];
    end
  end

  // Compensate and remove the calibration offset, wrapping to 16 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_valid_r <= 1'b0;
    end else begin
      sample_valid_r <= cj_valid;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= tip_dly_r[TIP_DLY-1] + cj - calibration_offset_r;
  end

  // Raw sample to fx9.7 Celsius
  tlc_pwl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FORWARD       (1'b1)
  ) u_pwl_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_valid_r),
    .in_x      (sample_r),
    .out_valid (fx_valid),
    .out_y     (fx97)
  );

  // Output units and result register
  tlc_units u_units (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (fx_valid),
    .in_fx97        (fx97),
    .out_valid      (out_valid),
    .out_fx97       (out_temp_fx97),
    .out_celsius    (out_temp_celsius),
    .out_fahrenheit (out_temp_fahrenheit)
  );

  // Checks
`include "thermocouple_linearizer_cjc_macros.svh"

  `TLC_ASSERT_IMP(a_result_latency, out_valid, $past(in_req, LAT))
  `TLC_ASSERT_IMP(a_fahrenheit_range, out_valid, (out_temp_fahrenheit >= 10'd32) && (out_temp_fahrenheit <= 10'd951))
  `TLC_ASSERT_NXT(a_cfg_write, cfg_wr && cfg_hit, calibration_offset_r == $past(pwdata[15:0]))

endmodule
